// ===== rtl/fdp_pkg.sv =====
// ----------------------------------------------------------------------------
// fdp_pkg: shared widths, types and codes of the feathered disc painter
// Holds the field widths, the register codes and the records that travel
// between the configuration block, the distance stages and the ramp steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdp_pkg;

	// Largest image side; sets the coordinate width.
	localparam int MAX_DIM = 1024;
	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int PIX_W   = 8;
	localparam int CFG_W   = 12;

	// Signed column and row offsets from the centre, and their squares.
	localparam int DX_W  = (COORD_W >= CFG_W) ? COORD_W + 2 : CFG_W + 1;
	localparam int SQ1_W = 2 * DX_W - 2;
	localparam int D2_W  = SQ1_W + 1;

	// Effective outer radius may reach 4096, one bit above the register.
	localparam int RAD_W   = CFG_W + 1;
	localparam int R1SQ_W  = 2 * CFG_W;
	localparam int R2SQ_W  = 2 * RAD_W - 1;
	localparam int CMP_W   = (D2_W > R2SQ_W) ? D2_W : R2SQ_W;

	// Ramp search: 255*R fits BASE_W bits, remainders are signed T_W bits.
	localparam int RAMP_BITS = PIX_W;
	localparam int BASE_W    = RAD_W + PIX_W - 1;
	localparam int T_W       = BASE_W + 1;
	localparam int SQ_W      = 2 * BASE_W;
	localparam int SCALE_W   = 2 * PIX_W;
	localparam int K_W       = D2_W + SCALE_W;
	localparam int KC_W      = (K_W > SQ_W) ? K_W : SQ_W;

	localparam logic [PIX_W-1:0]   PIX_MAX  = '1;
	localparam logic [SCALE_W-1:0] SCALE_SQ = SCALE_W'(PIX_MAX) * SCALE_W'(PIX_MAX);

	// Request word on the input stream, padded to whole bytes.
	localparam int TDATA_IN_W = ((2 * COORD_W + PIX_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		REG_CENTER_COL   = 2'd0,
		REG_CENTER_ROW   = 2'd1,
		REG_INNER_RADIUS = 2'd2,
		REG_OUTER_RADIUS = 2'd3
	} reg_idx_t;

	// Configuration as the datapath sees it, with derived terms.
	typedef struct packed {
		logic signed [CFG_W-1:0] center_col;
		logic signed [CFG_W-1:0] center_row;
		logic [R1SQ_W-1:0]       r1sq;
		logic [R2SQ_W-1:0]       r2sq;
		logic [BASE_W-1:0]       base;
		logic [RAD_W-1:0]        span;
	} cfg_t;

	// One pixel on its way through the ramp search.
	typedef struct packed {
		logic                  core;
		logic                  band;
		logic [PIX_W-1:0]      pix;
		logic [K_W-1:0]        k;
		logic signed [T_W-1:0] tc;
		logic [BASE_W-1:0]     tv;
		logic [RAMP_BITS-1:0]  v;
	} ramp_t;

endpackage

// ===== rtl/fdp_cfg.sv =====
// ----------------------------------------------------------------------------
// fdp_cfg: configuration registers
// Holds the four registers and derives the effective outer radius, the ramp
// span, both squared radii and 255 times the outer radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdp_cfg
	import fdp_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wen,
	input  logic [$bits(reg_idx_t)-1:0]  index,
	input  logic [CFG_W-1:0]             wdata,
	output cfg_t                         cfg
);

	logic signed [CFG_W-1:0] cc_q;
	logic signed [CFG_W-1:0] cr_q;
	logic [CFG_W-1:0]        inner_q;
	logic [CFG_W-1:0]        outer_q;

	logic [CFG_W-1:0]  r1_q;
	logic [RAD_W-1:0]  r2e_q;
	logic [RAD_W-1:0]  span_q;
	logic [R1SQ_W-1:0] r1sq_q;
	logic [R2SQ_W-1:0] r2sq_q;
	logic [BASE_W-1:0] base_q;

	logic [RAD_W-1:0] r2e_c;
	logic [RAD_W-1:0] span_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q    <= '0;
			cr_q    <= '0;
			inner_q <= '0;
			outer_q <= CFG_W'(1);
		end else if (wen) begin
			case (reg_idx_t'(index))
				REG_CENTER_COL:   cc_q    <= wdata;
				REG_CENTER_ROW:   cr_q    <= wdata;
				REG_INNER_RADIUS: inner_q <= wdata;
				REG_OUTER_RADIUS: outer_q <= wdata;
				default: ;
			endcase
		end
	end

	// Raise the outer radius to inner + 1 when it is not larger.
	always_comb begin
		r2e_c  = (outer_q <= inner_q) ? RAD_W'(inner_q) + RAD_W'(1) : RAD_W'(outer_q);
		span_c = r2e_c - RAD_W'(inner_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r1_q   <= '0;
			r2e_q  <= RAD_W'(1);
			span_q <= RAD_W'(1);
			r1sq_q <= '0;
			r2sq_q <= R2SQ_W'(1);
			base_q <= BASE_W'(PIX_MAX);
		end else begin
			r1_q   <= inner_q;
			r2e_q  <= r2e_c;
			span_q <= span_c;
			r1sq_q <= R1SQ_W'(r1_q) * R1SQ_W'(r1_q);
			r2sq_q <= R2SQ_W'(r2e_q) * R2SQ_W'(r2e_q);
			base_q <= BASE_W'(r2e_q) * BASE_W'(PIX_MAX);
		end
	end

	assign cfg.center_col = cc_q;
	assign cfg.center_row = cr_q;
	assign cfg.r1sq       = r1sq_q;
	assign cfg.r2sq       = r2sq_q;
	assign cfg.base       = base_q;
	assign cfg.span       = span_q;

endmodule

// ===== rtl/fdp_dist.sv =====
// ----------------------------------------------------------------------------
// fdp_dist: squared distance and classification stages
// Four stages: offsets, squares, sum, then core/band flags, the scaled
// distance 65025*d2 and the first candidate of the ramp search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdp_dist
	import fdp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	input  logic [PIX_W-1:0]   pix,
	input  cfg_t               cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output ramp_t              out_data
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [DX_W-1:0] dx_s1, dy_s1;
	logic [PIX_W-1:0]       pix_s1, pix_s2, pix_s3;
	logic [SQ1_W-1:0]       dxsq_s2, dysq_s2;
	logic [D2_W-1:0]        d2_s3;
	ramp_t                  data_s4;

	logic signed [2*DX_W-1:0] dxsq_c, dysq_c;
	logic [BASE_W-1:0]        span_top_c;

	assign rdy4     = !valid_s4 || out_ready;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	assign dxsq_c     = dx_s1 * dx_s1;
	assign dysq_c     = dy_s1 * dy_s1;
	assign span_top_c = BASE_W'(cfg.span) << (RAMP_BITS - 1);

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			dx_s1  <= DX_W'(col) - DX_W'(cfg.center_col);
			dy_s1  <= DX_W'(row) - DX_W'(cfg.center_row);
			pix_s1 <= pix;
		end
		if (rdy2 && valid_s1) begin
			dxsq_s2 <= dxsq_c[SQ1_W-1:0];
			dysq_s2 <= dysq_c[SQ1_W-1:0];
			pix_s2  <= pix_s1;
		end
		if (rdy3 && valid_s2) begin
			d2_s3  <= D2_W'(dxsq_s2) + D2_W'(dysq_s2);
			pix_s3 <= pix_s2;
		end
		if (rdy4 && valid_s3) begin
			data_s4.core <= CMP_W'(d2_s3) <= CMP_W'(cfg.r1sq);
			data_s4.band <= CMP_W'(d2_s3) <= CMP_W'(cfg.r2sq);
			data_s4.pix  <= pix_s3;
			data_s4.k    <= K_W'(d2_s3) * K_W'(SCALE_SQ);
			data_s4.tc   <= $signed({1'b0, cfg.base}) - $signed({1'b0, span_top_c});
			data_s4.tv   <= cfg.base;
			data_s4.v    <= '0;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ===== rtl/fdp_step.sv =====
// ----------------------------------------------------------------------------
// fdp_step: one bit of the ramp search
// Square the candidate remainder, then keep or drop the candidate bit and
// form the remainder for the next lower bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fdp_step
	import fdp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ramp_t                in_data,
	input  logic [RAMP_BITS-1:0] bit_mask,
	input  logic [BASE_W-1:0]    span_next,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ramp_t                out_data
);

	logic valid_s1, valid_s2;
	logic rdy1, rdy2;

	ramp_t            data_s1, data_s2;
	logic [SQ_W-1:0]  sq_s1;
	logic             neg_s1;

	logic [BASE_W-1:0]     mag_c;
	logic [SQ_W-1:0]       sq_c;
	logic                  take_c;
	logic signed [T_W-1:0] span_ext_c;
	logic signed [T_W-1:0] tc_keep_c;
	logic signed [T_W-1:0] tc_skip_c;

	assign rdy2     = !valid_s2 || out_ready;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
		end
	end

	assign mag_c = in_data.tc[BASE_W-1:0];
	assign sq_c  = SQ_W'(mag_c) * SQ_W'(mag_c);

	// Keep the bit when the remainder is non-negative and its square covers
	// the scaled distance.
	always_comb begin
		take_c     = !neg_s1 && (KC_W'(sq_s1) >= KC_W'(data_s1.k));
		span_ext_c = $signed({1'b0, span_next});
		tc_keep_c  = data_s1.tc - span_ext_c;
		tc_skip_c  = $signed({1'b0, data_s1.tv}) - span_ext_c;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			data_s1 <= in_data;
			sq_s1   <= sq_c;
			neg_s1  <= in_data.tc[T_W-1];
		end
		if (rdy2 && valid_s1) begin
			data_s2.core <= data_s1.core;
			data_s2.band <= data_s1.band;
			data_s2.pix  <= data_s1.pix;
			data_s2.k    <= data_s1.k;
			data_s2.v    <= take_c ? (data_s1.v | bit_mask) : data_s1.v;
			data_s2.tv   <= take_c ? data_s1.tc[BASE_W-1:0] : data_s1.tv;
			data_s2.tc   <= take_c ? tc_keep_c : tc_skip_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== rtl/feathered_disc_painter.sv =====
// ----------------------------------------------------------------------------
// feathered_disc_painter: white disc with a linear feathered edge
// Throughput: one pixel per cycle while m_tready is high; every stage owns a valid bit and stalls only.
// Reset: arst_n clears all valid bits and sets the registers to their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feathered_disc_painter
	import fdp_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream. s_tdata, from bit 0 up: col, row, pixel_in, zero padding.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [TDATA_IN_W-1:0]       s_tdata,
	// Output stream. m_tdata: pixel_out.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [PIX_W-1:0]            m_tdata,
	// Register writes: 0 centre column, 1 centre row, 2 inner, 3 outer radius.
	input  logic                        cfg_wen,
	input  logic [$bits(reg_idx_t)-1:0] cfg_index,
	input  logic [CFG_W-1:0]            cfg_wdata
);

	cfg_t  cfg;

	// Handshake chain between the distance stages and the eight ramp steps.
	// Index 0 leaves the distance block, index RAMP_BITS leaves the last step.
	logic  chain_valid [RAMP_BITS+1];
	logic  chain_ready [RAMP_BITS+1];
	ramp_t chain_data  [RAMP_BITS+1];

	ramp_t last;

	// Registers and derived terms. Derived terms are registered behind a write and
	// settle well before a following request reaches the stages using them.
	fdp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Distance stages: unpack the request, square the offsets, classify the
	// pixel and seed the ramp search with the top candidate bit.
	fdp_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.col       (s_tdata[COORD_W-1:0]),
		.row       (s_tdata[2*COORD_W-1:COORD_W]),
		.pix       (s_tdata[2*COORD_W+PIX_W-1:2*COORD_W]),
		.cfg       (cfg),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	// Ramp search, most significant bit first. Each step decides one bit of
	// floor(255*(R - sqrt(d2))/(R - inner)) and hands the next step its
	// remainder less the span shifted to the next bit weight.
	for (genvar gi = 0; gi < RAMP_BITS; gi++) begin : g_step
		logic [BASE_W-1:0] span_next;

		if (gi < RAMP_BITS - 1) begin : g_shift
			assign span_next = BASE_W'(cfg.span) << (RAMP_BITS - 2 - gi);
		end else begin : g_last
			// No lower bit follows: the next remainder is never used.
			assign span_next = '0;
		end

		fdp_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[gi]),
			.in_ready  (chain_ready[gi]),
			.in_data   (chain_data[gi]),
			.bit_mask  (RAMP_BITS'(1) << (RAMP_BITS - 1 - gi)),
			.span_next (span_next),
			.out_valid (chain_valid[gi+1]),
			.out_ready (chain_ready[gi+1]),
			.out_data  (chain_data[gi+1])
		);
	end

	// The last step's register is the output register: pick white for the
	// core, the ramp value for the band and the original pixel elsewhere.
	assign last                   = chain_data[RAMP_BITS];
	assign m_tvalid               = chain_valid[RAMP_BITS];
	assign chain_ready[RAMP_BITS] = m_tready;
	assign m_tdata                = last.core ? PIX_MAX : (last.band ? last.v : last.pix);

`ifndef SYNTH
	// The ramp never reaches white outside the core.
	a_ramp_below_white: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && last.band && !last.core |-> last.v != PIX_MAX)
		else $error("ramp value reached white outside the core");

	// The core lies inside the band, since the outer radius exceeds the inner.
	a_core_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && last.core |-> last.band)
		else $error("core pixel flagged outside the band");

	// Derived radii keep a non-empty ramp at every cycle.
	a_radii_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.span != '0 && R2SQ_W'(cfg.r1sq) < cfg.r2sq)
		else $error("derived radii out of order");
`endif

endmodule

// ===== bench/feathered_disc_painter_tb.sv =====
// ----------------------------------------------------------------------------
// feathered_disc_painter_tb: self-checking bench for the feathered disc painter
// Streams pixel requests through the painter under a series of disc settings,
// predicts every painted pixel in integer arithmetic and checks each result in
// order, with random gaps and stalls on both streams and two long output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module feathered_disc_painter_tb;
	import fdp_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 11;
	// Pipeline depth from the head of the block; it also sets the tail wait.
	localparam int PIPE_DEPTH   = 20;
	localparam int HOLD_CYCLES  = 300;
	localparam int RAND_PHASES  = 14;
	localparam int PHASE_ITEMS  = 100;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_GAP      = 5;
	localparam int COORD_MAX    = MAX_DIM - 1;
	// Marks a table row whose result comes from the predictor.
	localparam int PREDICT      = -1;
	localparam int DIR_COUNT    = 24;

	// One row of the directed table. With set_disc high the four disc
	// registers are rewritten (block drained first) before the pixel is sent.
	typedef struct packed {
		bit set_disc;
		int cc;
		int cr;
		int ri;
		int ro;
		int col;
		int row;
		int pix;
		int want;
	} paint_row_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	// s_tdata, from bit 0 up: col, row, pixel_in, zero padding.
	logic [TDATA_IN_W-1:0]       s_tdata   = '0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	// m_tdata: pixel_out.
	logic [PIX_W-1:0]            m_tdata;
	logic                        cfg_wen   = 1'b0;
	logic [$bits(reg_idx_t)-1:0] cfg_index = REG_CENTER_COL;
	logic [CFG_W-1:0]            cfg_wdata = '0;

	// Bench copy of the disc registers, starting from their reset values.
	logic signed [CFG_W-1:0] disc_col = '0;
	logic signed [CFG_W-1:0] disc_row = '0;
	logic [CFG_W-1:0]        core_rad = '0;
	logic [CFG_W-1:0]        edge_rad = CFG_W'(1);

	// Painted pixels still owed by the block, oldest first.
	logic [PIX_W-1:0] painted_due [$];
	int               faults       = 0;
	// Shared pacing controls: steady drops all idling on both sides,
	// hold_out_req asks the output side for one long stall.
	bit               steady       = 1'b0;
	bit               hold_out_req = 1'b0;

	paint_row_t dir_rows [DIR_COUNT] = '{
		// Reset settings: centre at the origin, core 0, outer 1.
		'{1'b0,     0,     0,    0,    0,    0,    0, 'h00,     255},
		'{1'b0,     0,     0,    0,    0,    1,    0, 'h5A,       0},
		'{1'b0,     0,     0,    0,    0,    1,    1, 'h5A,    'h5A},
		'{1'b0,     0,     0,    0,    0, 1023, 1023, 'hFF,    'hFF},
		'{1'b0,     0,     0,    0,    0, 1023,    0, 'h00,       0},
		'{1'b0,     0,     0,    0,    0,    0, 1023, 'hA5,    'hA5},
		// Centre far off the top left, largest core, outer below it.
		'{1'b1, -1024, -1024, 2048,    0,    0,    0, 'h3C,     255},
		'{1'b0,     0,     0,    0,    0, 1023, 1023, 'h3C,    'h3C},
		'{1'b0,     0,     0,    0,    0,    0, 1023, 'h81,    'h81},
		// Centre off the bottom right, no core, widest ramp.
		'{1'b1,  1024,  1024,    0, 2048, 1023, 1023, 'h10, PREDICT},
		'{1'b0,     0,     0,    0,    0,    0,    0, 'h10, PREDICT},
		'{1'b0,     0,     0,    0,    0,    0, 1023, 'h10, PREDICT},
		'{1'b0,     0,     0,    0,    0,  512,    0, 'h10, PREDICT},
		// Outer equal to inner: ramp one pixel wide.
		'{1'b1,   512,   512,  100,  100,  612,  512, 'h00,     255},
		'{1'b0,     0,     0,    0,    0,  613,  512, 'h00,       0},
		'{1'b0,     0,     0,    0,    0,  614,  512, 'h77,    'h77},
		'{1'b0,     0,     0,    0,    0,  512,  411, 'h77,       0},
		'{1'b0,     0,     0,    0,    0,  600,  560, 'h77, PREDICT},
		// Outer below inner.
		'{1'b1,     0,     0,   10,    5,   10,    0, 'hEE,     255},
		'{1'b0,     0,     0,    0,    0,   11,    0, 'hEE,       0},
		'{1'b0,     0,     0,    0,    0,    0,   12, 'hC3,    'hC3},
		'{1'b0,     0,     0,    0,    0,    7,    8, 'hC3, PREDICT},
		// Ordinary ramp: just past the core, and exactly on the rim.
		'{1'b1,   512,   512,  100,  200,  613,  512, 'h00, PREDICT},
		'{1'b0,     0,     0,    0,    0,  712,  512, 'hFF,       0}
	};

	feathered_disc_painter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Paint one pixel as the block should: solid core, exact integer ramp
	// found bit by bit, pass-through outside the effective outer radius.
	function automatic logic [PIX_W-1:0] predict_paint(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row, input logic [PIX_W-1:0] pix);
		longint dx, dy, d2, r1, r2, span, cand, rest, level, full;
		full = longint'(PIX_MAX);
		dx = longint'(col) - longint'(disc_col);
		dy = longint'(row) - longint'(disc_row);
		d2 = dx * dx + dy * dy;
		r1 = longint'(core_rad);
		r2 = longint'(edge_rad);
		// Raise a collapsed outer radius to one past the core.
		if (r2 <= r1)
			r2 = r1 + 1;
		span = r2 - r1;
		if (d2 <= r1 * r1)
			return PIX_MAX;
		if (d2 > r2 * r2)
			return pix;
		// Largest level with full*(r2 - sqrt(d2)) >= level*span, squared out.
		level = 0;
		for (longint b = 128; b > 0; b >>= 1) begin
			cand = level | b;
			rest = full * r2 - cand * span;
			if (rest >= 0 && rest * rest >= full * full * d2)
				level = cand;
		end
		return PIX_W'(level);
	endfunction

	// Write one disc register; the block must be idle.
	task automatic put_reg(input reg_idx_t idx, input int value);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
	endtask

	// Rewrite all four disc registers and mirror them in the bench copy.
	task automatic write_disc(input int cc, input int cr, input int ri, input int ro);
		put_reg(REG_CENTER_COL, cc);
		put_reg(REG_CENTER_ROW, cr);
		put_reg(REG_INNER_RADIUS, ri);
		put_reg(REG_OUTER_RADIUS, ro);
		cfg_wen  <= 1'b0;
		disc_col = CFG_W'(cc);
		disc_row = CFG_W'(cr);
		core_rad = CFG_W'(ri);
		edge_rad = CFG_W'(ro);
	endtask

	// Drop the input request and hold until every owed pixel has come back.
	task automatic quiesce_stream();
		s_tvalid <= 1'b0;
		while (painted_due.size() != 0)
			@(posedge clk);
	endtask

	// Offer one pixel request after a random gap and wait for its acceptance.
	// tvalid is left high so a zero gap on the next request keeps it up.
	task automatic send_pixel(input int col, input int row, input int pix, input int want);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_IN_W'({PIX_W'(pix), COORD_W'(row), COORD_W'(col)});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (want == PREDICT)
			painted_due.push_back(predict_paint(COORD_W'(col), COORD_W'(row), PIX_W'(pix)));
		else
			painted_due.push_back(PIX_W'(want));
	endtask

	// Reset once, at the start.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Output side: stall at random per result, take one long stall on request,
	// and check each accepted pixel against the oldest owed one.
	initial begin : collect_painted
		int stall;
		logic [PIX_W-1:0] want;
		// Hold off until the block is out of reset and its valid bits are known.
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_out_req) begin
				hold_out_req = 1'b0;
				m_tready <= 1'b0;
				// Count the stretch here so the input side keeps pushing meanwhile.
				for (int n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
			end
			stall = steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (painted_due.size() == 0) begin
				$display("%0t: pixel_out expected none, actual %0d", $time, m_tdata);
				faults++;
			end else begin
				want = painted_due.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: pixel_out expected %0d, actual %0d", $time, want, m_tdata);
					faults++;
				end
			end
		end
	end

	// Generous cycle budget; reaching it means the block has hung.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Stimulus: directed table first, then random phases with fresh settings.
	initial begin : stimulus
		int cc, cr, ri, ro, reach, col, row;
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		// Walk the directed table; registers change only with the block drained.
		for (int i = 0; i < DIR_COUNT; i++) begin
			if (dir_rows[i].set_disc) begin
				quiesce_stream();
				write_disc(dir_rows[i].cc, dir_rows[i].cr, dir_rows[i].ri, dir_rows[i].ro);
			end
			send_pixel(dir_rows[i].col, dir_rows[i].row, dir_rows[i].pix, dir_rows[i].want);
		end

		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			// Pause until the block is empty, then pick a new disc.
			quiesce_stream();
			cc = int'($urandom_range(0, 2048)) - 1024;
			cr = int'($urandom_range(0, 2048)) - 1024;
			if ($urandom_range(0, 5) == 0)
				cc = $urandom_range(0, 1) ? 1024 : -1024;
			if ($urandom_range(0, 5) == 0)
				cr = $urandom_range(0, 1) ? 1024 : -1024;
			case ($urandom_range(0, 7))
				0: ri = 0;
				1: ri = 2048;
				2: ri = $urandom_range(0, 2048);
				default: ri = $urandom_range(0, 150);
			endcase
			if ($urandom_range(0, 4) == 0)
				ro = $urandom_range(0, ri);
			else if ($urandom_range(0, 3) == 0)
				ro = $urandom_range(0, 2048);
			else
				ro = ri + 1 + $urandom_range(0, 200);
			if (ro > 2048)
				ro = 2048;
			write_disc(cc, cr, ri, ro);

			// Some phases run flat out; two take a long output stall so the
			// pipeline fills and pushes back on the input.
			steady       = (phase % 4 == 3);
			hold_out_req = (phase == 5 || phase == 11);
			reach        = ((ro > ri) ? ro : ri + 1) + 3;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Mostly aim around the disc so core, ramp and rim are hit.
				if ($urandom_range(0, 3) != 0) begin
					col = cc + int'($urandom_range(0, 2 * reach)) - reach;
					row = cr + int'($urandom_range(0, 2 * reach)) - reach;
					if (col < 0)
						col = 0;
					if (col > COORD_MAX)
						col = COORD_MAX;
					if (row < 0)
						row = 0;
					if (row > COORD_MAX)
						row = COORD_MAX;
				end else begin
					col = $urandom_range(0, COORD_MAX);
					row = $urandom_range(0, COORD_MAX);
				end
				send_pixel(col, row, $urandom_range(0, 255), PREDICT);
			end
		end

		// Drain, then watch a while longer for stray results.
		quiesce_stream();
		steady = 1'b0;
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (faults == 0 && painted_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
